[sv/csq_pkg.sv]
// Shared constants for the counting semaphore with FIFO wait queue.
// Status codes, command and register indexes, default sizes. No dependencies.
package csq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int MAX_TASKS_DEF   = 8;

  localparam int CNT_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HANDED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_QFULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RFULL   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ISR     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_IRQ     = 3'd7;

  // commands
  localparam logic CMD_WAIT   = 1'b0;
  localparam logic CMD_SIGNAL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT     = 2'd1;

endpackage

[sv/csq_ring.sv]
// Wait-queue storage: single write port, single read port, registered read data.
// Depends on nothing; sizes come from the top level.
module csq_ring #(
  parameter int DEPTH  = 8,
  parameter int DATA_W = 3,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/counting_semaphore_wait_queue.sv]
// Counting semaphore with a FIFO queue of waiting task ids. An accepted request's result
// is registered; a signal that releases a waiter passes through the S_WAKE state first,
// as the oldest id is read from the ring memory, whose read data is registered. Another
// request is taken once the block is back in S_IDLE and the result register is free or
// being drained. Writing initial_count reloads the count (clamped to max_count) and
// empties the queue at once. Depends on csq_pkg and csq_ring.
module counting_semaphore_wait_queue #(
  parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_TASKS   = csq_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          cmd,
  input  logic [$clog2(MAX_TASKS)-1:0]  task_id,
  input  logic                          kernel_running,
  input  logic                          in_isr,
  input  logic                          irqs_masked,
  // result channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [csq_pkg::STATUS_W-1:0]  status,
  output logic                          woken_valid,
  output logic [$clog2(MAX_TASKS)-1:0]  woken_task,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csq_pkg::CNT_W-1:0]     cfg_data
);

  localparam int TASK_W = $clog2(MAX_TASKS);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int WC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [WC_W-1:0]  WC_FULL  = WC_W'(QUEUE_DEPTH);

  typedef enum logic {S_IDLE, S_WAKE} state_t;

  state_t                      state;
  logic [csq_pkg::CNT_W-1:0]   sem_count;
  logic [csq_pkg::CNT_W-1:0]   max_count;
  logic [PTR_W-1:0]            ring_head;
  logic [PTR_W-1:0]            ring_tail;
  logic [WC_W-1:0]             waiter_count;

  logic                        accept;
  logic                        ctx_err;
  logic [csq_pkg::STATUS_W-1:0] ctx_status;
  logic                        do_take;
  logic                        do_push;
  logic                        do_pop;
  logic                        do_give;
  logic [csq_pkg::STATUS_W-1:0] dec_status;
  logic [PTR_W-1:0]            head_next;
  logic [PTR_W-1:0]            tail_next;
  logic [TASK_W-1:0]           ring_rd_data;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  // context checks, in priority order
  always_comb begin
    ctx_err    = 1'b1;
    ctx_status = csq_pkg::ST_INVALID;
    if (!kernel_running) begin
      ctx_status = csq_pkg::ST_INVALID;
    end else if (in_isr) begin
      ctx_status = csq_pkg::ST_ISR;
    end else if (irqs_masked) begin
      ctx_status = csq_pkg::ST_IRQ;
    end else begin
      ctx_err = 1'b0;
    end
  end

  always_comb begin
    do_take    = 1'b0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_give    = 1'b0;
    dec_status = ctx_status;
    if (!ctx_err) begin
      if (cmd == csq_pkg::CMD_WAIT) begin
        if (sem_count != '0) begin
          do_take    = 1'b1;
          dec_status = csq_pkg::ST_OK;
        end else if (waiter_count == WC_FULL) begin
          dec_status = csq_pkg::ST_QFULL;
        end else begin
          do_push    = 1'b1;
          dec_status = csq_pkg::ST_BLOCKED;
        end
      end else begin
        if (waiter_count != '0) begin
          do_pop     = 1'b1;
          dec_status = csq_pkg::ST_HANDED;
        end else if (sem_count >= max_count) begin
          dec_status = csq_pkg::ST_RFULL;
        end else begin
          do_give    = 1'b1;
          dec_status = csq_pkg::ST_OK;
        end
      end
    end
  end

  assign head_next = (ring_head == PTR_LAST) ? '0 : ring_head + 1'b1;
  assign tail_next = (ring_tail == PTR_LAST) ? '0 : ring_tail + 1'b1;

  csq_ring #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (TASK_W),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept && do_push),
    .wr_addr (ring_tail),
    .wr_data (task_id),
    .rd_en   (accept && do_pop),
    .rd_addr (ring_head),
    .rd_data (ring_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      sem_count    <= '0;
      max_count    <= csq_pkg::CNT_W'(1);
      ring_head    <= '0;
      ring_tail    <= '0;
      waiter_count <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      // config writes must arrive only while idle; the user keeps to this, the block does not enforce it
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == csq_pkg::REG_INITIAL_COUNT) begin
          sem_count    <= (cfg_data < max_count) ? cfg_data : max_count;
          ring_head    <= '0;
          ring_tail    <= '0;
          waiter_count <= '0;
        end else if (cfg_index == csq_pkg::REG_MAX_COUNT) begin
          max_count <= cfg_data;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (do_take) begin
              sem_count <= sem_count - 1'b1;
            end
            if (do_give) begin
              sem_count <= sem_count + 1'b1;
            end
            if (do_push) begin
              ring_tail    <= tail_next;
              waiter_count <= waiter_count + 1'b1;
            end
            if (do_pop) begin
              ring_head    <= head_next;
              waiter_count <= waiter_count - 1'b1;
              state        <= S_WAKE;
            end else begin
              rsp_valid   <= 1'b1;
              status      <= dec_status;
              woken_valid <= 1'b0;
              woken_task  <= '0;
            end
          end
        end
        S_WAKE: begin
          // ring read data lands this cycle
          rsp_valid   <= 1'b1;
          status      <= csq_pkg::ST_HANDED;
          woken_valid <= 1'b1;
          woken_task  <= ring_rd_data;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for counting_semaphore_wait_queue: directed and random wait/signal requests,
// each result checked in order against a predictor of the count and the wait ring.
// Depends on csq_pkg and the block's RTL.
module tb;

  localparam int TID_W  = $clog2(csq_pkg::MAX_TASKS_DEF);
  localparam int QDEPTH = csq_pkg::QUEUE_DEPTH_DEF;
  localparam int QPTR_W = $clog2(QDEPTH);

  // register indexes the block does not decode
  localparam logic [csq_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [csq_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic             cmd;
    logic [TID_W-1:0] task_id;
    logic             running;
    logic             isr;
    logic             masked;
  } sem_req_t;

  typedef struct packed {
    logic [csq_pkg::STATUS_W-1:0] status;
    logic                         woken_valid;
    logic [TID_W-1:0]             woken_task;
  } sem_rsp_t;

  logic                          clk            = 1'b0;
  logic                          rst            = 1'b1;
  logic                          req_valid      = 1'b0;
  logic                          req_stall;
  logic                          cmd            = csq_pkg::CMD_WAIT;
  logic [TID_W-1:0]              task_id        = '0;
  logic                          kernel_running = 1'b0;
  logic                          in_isr         = 1'b0;
  logic                          irqs_masked    = 1'b0;
  logic                          rsp_valid;
  logic                          rsp_stall      = 1'b1;
  logic [csq_pkg::STATUS_W-1:0]  status;
  logic                          woken_valid;
  logic [TID_W-1:0]              woken_task;
  logic                          cfg_valid      = 1'b0;
  logic                          cfg_ready;
  logic [csq_pkg::CFG_IDX_W-1:0] cfg_index      = csq_pkg::REG_INITIAL_COUNT;
  logic [csq_pkg::CNT_W-1:0]     cfg_data       = '0;

  // predictor state
  logic [csq_pkg::CNT_W-1:0] init_reg;
  logic [csq_pkg::CNT_W-1:0] limit_reg;
  logic [csq_pkg::CNT_W-1:0] sem_count;
  logic [TID_W-1:0]          wait_ring [QDEPTH];
  logic [QPTR_W-1:0]         ring_rd;
  logic [QPTR_W-1:0]         ring_wr;
  logic [QPTR_W:0]           waiters;

  sem_req_t req_backlog[$];
  sem_rsp_t rsp_due[$];
  int       n_pushed      = 0;
  int       n_taken       = 0;
  int       mismatches    = 0;
  int       send_idle_pct = 23;
  int       recv_idle_pct = 87;
  bit       req_taken     = 1'b0;
  bit       hold_go       = 1'b0;
  logic     hold_rsp      = 1'b0;

  counting_semaphore_wait_queue u_top (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .cmd            (cmd),
    .task_id        (task_id),
    .kernel_running (kernel_running),
    .in_isr         (in_isr),
    .irqs_masked    (irqs_masked),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .woken_valid    (woken_valid),
    .woken_task     (woken_task),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  function automatic void sem_reload();
    sem_count = (init_reg < limit_reg) ? init_reg : limit_reg;
    ring_rd   = '0;
    ring_wr   = '0;
    waiters   = '0;
  endfunction

  function automatic sem_rsp_t sem_step(sem_req_t r);
    sem_rsp_t o;
    o = '{status: csq_pkg::ST_OK, woken_valid: 1'b0, woken_task: '0};
    if (!r.running) begin
      o.status = csq_pkg::ST_INVALID;
    end else if (r.isr) begin
      o.status = csq_pkg::ST_ISR;
    end else if (r.masked) begin
      o.status = csq_pkg::ST_IRQ;
    end else if (r.cmd == csq_pkg::CMD_WAIT) begin
      if (sem_count != 0) begin
        sem_count = sem_count - 1'b1;
      end else if (waiters == QDEPTH) begin
        o.status = csq_pkg::ST_QFULL;
      end else begin
        wait_ring[ring_wr] = r.task_id;
        ring_wr  = ring_wr + 1'b1;
        waiters  = waiters + 1'b1;
        o.status = csq_pkg::ST_BLOCKED;
      end
    end else begin
      if (waiters != 0) begin
        o.woken_valid = 1'b1;
        o.woken_task  = wait_ring[ring_rd];
        ring_rd       = ring_rd + 1'b1;
        waiters       = waiters - 1'b1;
        o.status      = csq_pkg::ST_HANDED;
      end else if (sem_count >= limit_reg) begin
        o.status = csq_pkg::ST_RFULL;
      end else begin
        sem_count = sem_count + 1'b1;
      end
    end
    return o;
  endfunction

  // sample on the rising edge: register writes, accepted requests, returned results
  always @(posedge clk) begin : monitor
    sem_rsp_t want;
    sem_rsp_t got;
    req_taken = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          csq_pkg::REG_INITIAL_COUNT: begin
            init_reg = cfg_data;
            sem_reload();
          end
          csq_pkg::REG_MAX_COUNT: begin
            limit_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (req_valid && !req_stall) begin
        rsp_due.push_back(sem_step({cmd, task_id, kernel_running, in_isr, irqs_masked}));
        n_taken++;
        req_taken = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        got = {status, woken_valid, woken_task};
        if (rsp_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result status %0d woken %0b/%0d",
                     $time, got.status, got.woken_valid, got.woken_task);
          mismatches++;
        end else begin
          want = rsp_due.pop_front();
          if (got.status !== want.status || got.woken_valid !== want.woken_valid ||
              got.woken_task !== want.woken_task) begin
            if (mismatches < 10)
              $display("%0t: status/woken/task expected %0d/%0b/%0d got %0d/%0b/%0d",
                       $time, want.status, want.woken_valid, want.woken_task,
                       got.status, got.woken_valid, got.woken_task);
            mismatches++;
          end
        end
      end
    end
  end

  // drive on the falling edge; a request is held until it is taken
  always @(negedge clk) begin : driver
    sem_req_t nxt;
    if (!req_valid || req_taken) begin
      if (!rst && req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_backlog.pop_front();
        req_valid      <= 1'b1;
        cmd            <= nxt.cmd;
        task_id        <= nxt.task_id;
        kernel_running <= nxt.running;
        in_isr         <= nxt.isr;
        irqs_masked    <= nxt.masked;
      end else begin
        req_valid <= 1'b0;
      end
    end
    rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin : pressure
    wait (hold_go);
    @(negedge clk);
    hold_rsp <= 1'b1;
    repeat (150) @(negedge clk);
    hold_rsp <= 1'b0;
  end

  initial begin : watchdog
    #1_000_000;
    $display("FAIL counting_semaphore_wait_queue");
    $finish;
  end

  task automatic add_req(input logic c, input int tid, input logic run, input logic isr,
                         input logic msk);
    req_backlog.push_back({c, TID_W'(tid), run, isr, msk});
    n_pushed++;
  endtask

  task automatic add_plain(input logic c, input int tid);
    add_req(c, tid, 1'b1, 1'b0, 1'b0);
  endtask

  // runs biased towards waits or towards signals, so the queue fills and drains
  task automatic add_random(input int n);
    int run_left = 0;
    int wait_bias = 50;
    repeat (n) begin
      if (run_left == 0) begin
        run_left  = $urandom_range(12, 1);
        wait_bias = $urandom_range(1) ? 80 : 25;
      end
      run_left--;
      if ($urandom_range(99) < 88)
        add_plain(($urandom_range(99) < wait_bias) ? csq_pkg::CMD_WAIT : csq_pkg::CMD_SIGNAL,
                  int'($urandom_range(7)));
      else
        add_req(1'($urandom_range(1)), int'($urandom_range(7)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic settle();
    while (n_taken != n_pushed || rsp_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [csq_pkg::CFG_IDX_W-1:0] idx,
                         input logic [csq_pkg::CNT_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    init_reg  = '0;
    limit_reg = csq_pkg::CNT_W'(1);
    sem_reload();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: count 0, limit 1
    add_plain(csq_pkg::CMD_SIGNAL, 7);
    add_plain(csq_pkg::CMD_SIGNAL, 7);
    add_plain(csq_pkg::CMD_WAIT, 0);
    add_req(csq_pkg::CMD_WAIT, 3, 1'b0, 1'b1, 1'b1);   // not running beats the other checks
    add_req(csq_pkg::CMD_WAIT, 3, 1'b1, 1'b1, 1'b1);   // isr ahead of masked
    add_req(csq_pkg::CMD_SIGNAL, 4, 1'b1, 1'b0, 1'b1);
    for (int i = 0; i < QDEPTH; i++) add_plain(csq_pkg::CMD_WAIT, i);
    add_plain(csq_pkg::CMD_WAIT, 5);                   // queue full
    add_plain(csq_pkg::CMD_SIGNAL, 2);
    add_plain(csq_pkg::CMD_SIGNAL, 6);
    settle();

    // undecoded indexes must leave the queue alone
    set_reg(REG_SPARE_LO, '1);
    set_reg(REG_SPARE_HI, '0);
    add_plain(csq_pkg::CMD_SIGNAL, 0);
    settle();

    set_reg(csq_pkg::REG_MAX_COUNT, 16'hFFFF);
    set_reg(csq_pkg::REG_INITIAL_COUNT, 16'hFFFF);
    add_plain(csq_pkg::CMD_WAIT, 1);
    add_plain(csq_pkg::CMD_SIGNAL, 1);
    add_plain(csq_pkg::CMD_SIGNAL, 1);
    settle();

    // zero limit: reload clamps to 0, idle signal hits resource full
    set_reg(csq_pkg::REG_MAX_COUNT, '0);
    set_reg(csq_pkg::REG_INITIAL_COUNT, 16'd9);
    add_plain(csq_pkg::CMD_SIGNAL, 4);
    add_plain(csq_pkg::CMD_WAIT, 5);
    add_plain(csq_pkg::CMD_SIGNAL, 4);
    settle();

    // limit lowered below the count
    set_reg(csq_pkg::REG_MAX_COUNT, 16'd3);
    set_reg(csq_pkg::REG_INITIAL_COUNT, 16'd3);
    set_reg(csq_pkg::REG_MAX_COUNT, 16'd1);
    add_plain(csq_pkg::CMD_SIGNAL, 2);
    add_plain(csq_pkg::CMD_WAIT, 2);
    add_plain(csq_pkg::CMD_WAIT, 3);
    add_plain(csq_pkg::CMD_SIGNAL, 2);
    add_plain(csq_pkg::CMD_WAIT, 6);
    add_plain(csq_pkg::CMD_SIGNAL, 2);
    settle();

    set_reg(csq_pkg::REG_MAX_COUNT, 16'd3);
    set_reg(csq_pkg::REG_INITIAL_COUNT, 16'd2);
    add_random(150);
    settle();

    send_idle_pct = 87;
    recv_idle_pct = 23;
    set_reg(csq_pkg::REG_MAX_COUNT, 16'd1);
    set_reg(csq_pkg::REG_INITIAL_COUNT, '0);
    add_random(150);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_reg(csq_pkg::REG_MAX_COUNT, 16'd8);
    set_reg(csq_pkg::REG_INITIAL_COUNT, 16'd4);
    hold_go = 1'b1;
    add_random(40);
    settle();

    set_reg(csq_pkg::REG_MAX_COUNT, 16'd2);
    set_reg(csq_pkg::REG_INITIAL_COUNT, '0);
    add_random(110);
    settle();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && rsp_due.size() == 0)
      $display("PASS counting_semaphore_wait_queue");
    else
      $display("FAIL counting_semaphore_wait_queue");
    $finish;
  end

endmodule

[counting_semaphore_wait_queue.f]
sv/csq_pkg.sv
sv/csq_ring.sv
sv/counting_semaphore_wait_queue.sv
tb/sv/tb.sv
